// ===== rtl/csc_pkg.sv =====
// ---------------------------------------------------------------------------
// csc_pkg
// Shared types and constants for the Cohen-Sutherland line clipper.
// ---------------------------------------------------------------------------
package csc_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int MAX_MOVES       = 4;
	localparam int CFG_INDEX_W     = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_X_MIN = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_X_MAX = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_Y_MIN = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_Y_MAX = 2'd3;

	typedef struct packed {
		logic above;
		logic below;
		logic right;
		logic left;
	} outcode_t;

endpackage

// ===== rtl/line_clip_cohen_sutherland_top.sv =====
// ---------------------------------------------------------------------------
// line_clip_cohen_sutherland_top
// Cohen-Sutherland clipper for signed Q16.16 segments against a window.
// ---------------------------------------------------------------------------
// Usage:
//   cfg channel writes the window edges (index 0..3: x_min, x_max, y_min,
//   y_max); write only while no segment is in flight. All edges reset to 0.
//   s_tdata carries one segment per transaction. A segment that survives
//   clipping leaves as one m_tdata transaction; a dropped one gives none.
// Timing:
//   s_tready is high only while the sequencer is idle. A segment inside the
//   window passes the test and emit states into the output register. Each
//   edge move runs test, setup, shift-add multiply then restoring divide on
//   the shared adder of csc_muldiv, and apply, with at most four moves per
//   segment. The next segment is taken the cycle after a result is emitted
//   or the segment is dropped.
// Stall:
//   the result sits in the output register; the next segment is accepted
//   meanwhile and waits before its own emit until that register frees.
// Reset:
//   arst_n clears the sequencer, the output valid and the window registers.
// ---------------------------------------------------------------------------
module line_clip_cohen_sutherland_top
	import csc_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [CFG_INDEX_W-1:0]                cfg_index,
	input  logic [COORD_WIDTH-1:0]                cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// start_x, start_y, end_x, end_y, zero pad
	input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y, zero pad
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0]    m_tdata
);

	localparam int W       = COORD_WIDTH;
	localparam int DW      = COORD_WIDTH + 1;
	localparam int TD_W    = ((4*COORD_WIDTH+7)/8)*8;
	localparam int MOVES_W = $clog2(MAX_MOVES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_SETUP,
		ST_CALC,
		ST_APPLY,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [MOVES_W-1:0]    moves_q;
	logic signed [W-1:0]   x1_q, y1_q, x2_q, y2_q;
	logic signed [W-1:0]   x_min_q, x_max_q, y_min_q, y_max_q;
	logic signed [W-1:0]   edge_q;
	logic signed [W-1:0]   a1_q;
	logic                  axis_q;
	logic                  first_q;
	logic                  neg_q;
	logic                  zero_q;
	logic                  m_tvalid_q;
	logic [TD_W-1:0]       m_tdata_q;

	outcode_t              c1, c2, c_sel;
	logic signed [W-1:0]   a1, a2, b1, b2;
	logic signed [DW-1:0]  da, db, dd;
	logic [DW-1:0]         ma, mb, md;
	logic                  neg;
	logic                  md_start;
	logic [DW-1:0]         quot;
	logic                  md_done;
	logic [DW-1:0]         q_use;
	logic signed [DW:0]    moved;
	logic signed [W-1:0]   new_coord;
	logic                  emit_fire;

	// window registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= '0;
			x_max_q <= '0;
			y_min_q <= '0;
			y_max_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_X_MIN: x_min_q <= cfg_data;
				REG_X_MAX: x_max_q <= cfg_data;
				REG_Y_MIN: y_min_q <= cfg_data;
				REG_Y_MAX: y_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	csc_outcode #(.COORD_WIDTH(W)) u_code1 (
		.x(x1_q), .y(y1_q),
		.x_min(x_min_q), .x_max(x_max_q), .y_min(y_min_q), .y_max(y_max_q),
		.code(c1)
	);

	csc_outcode #(.COORD_WIDTH(W)) u_code2 (
		.x(x2_q), .y(y2_q),
		.x_min(x_min_q), .x_max(x_max_q), .y_min(y_min_q), .y_max(y_max_q),
		.code(c2)
	);

	assign c_sel = (c1 != '0) ? c1 : c2;

	// cut operands: axis 0 moves onto a y edge, axis 1 onto an x edge
	always_comb begin
		a1  = axis_q ? y1_q : x1_q;
		a2  = axis_q ? y2_q : x2_q;
		b1  = axis_q ? x1_q : y1_q;
		b2  = axis_q ? x2_q : y2_q;
		da  = {a2[W-1], a2} - {a1[W-1], a1};
		db  = {edge_q[W-1], edge_q} - {b1[W-1], b1};
		dd  = {b2[W-1], b2} - {b1[W-1], b1};
		ma  = da[DW-1] ? DW'(-da) : DW'(da);
		mb  = db[DW-1] ? DW'(-db) : DW'(db);
		md  = dd[DW-1] ? DW'(-dd) : DW'(dd);
		neg = da[DW-1] ^ db[DW-1] ^ dd[DW-1];
	end

	assign md_start = (state_q == ST_SETUP) && (dd != '0);

	csc_muldiv #(.DW(DW)) u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(md_start),
		.ma(ma),
		.mb(mb),
		.md(md),
		.quot(quot),
		.done(md_done)
	);

	always_comb begin
		q_use     = zero_q ? '0 : quot;
		moved     = neg_q ? ({{2{a1_q[W-1]}}, a1_q} - {1'b0, q_use})
		                  : ({{2{a1_q[W-1]}}, a1_q} + {1'b0, q_use});
		new_coord = moved[W-1:0];
	end

	assign emit_fire = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			moves_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						moves_q <= '0;
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (c1 == '0 && c2 == '0) begin
						state_q <= ST_EMIT;
					end else if ((c1 & c2) != '0 || moves_q == MOVES_W'(MAX_MOVES)) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= (dd == '0) ? ST_APPLY : ST_CALC;
				end
				ST_CALC: begin
					if (md_done) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					moves_q <= moves_q + 1'b1;
					state_q <= ST_TEST;
				end
				ST_EMIT: begin
					if (emit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					x1_q <= s_tdata[0*W +: W];
					y1_q <= s_tdata[1*W +: W];
					x2_q <= s_tdata[2*W +: W];
					y2_q <= s_tdata[3*W +: W];
				end
			end
			ST_TEST: begin
				first_q <= (c1 != '0);
				if (c_sel.above) begin
					axis_q <= 1'b0;
					edge_q <= y_max_q;
				end else if (c_sel.below) begin
					axis_q <= 1'b0;
					edge_q <= y_min_q;
				end else if (c_sel.right) begin
					axis_q <= 1'b1;
					edge_q <= x_max_q;
				end else begin
					axis_q <= 1'b1;
					edge_q <= x_min_q;
				end
			end
			ST_SETUP: begin
				a1_q   <= a1;
				neg_q  <= neg;
				zero_q <= (dd == '0);
			end
			ST_APPLY: begin
				if (first_q) begin
					x1_q <= axis_q ? edge_q : new_coord;
					y1_q <= axis_q ? new_coord : edge_q;
				end else begin
					x2_q <= axis_q ? edge_q : new_coord;
					y2_q <= axis_q ? new_coord : edge_q;
				end
			end
			ST_EMIT: begin
				if (emit_fire) begin
					m_tdata_q <= TD_W'({y2_q, x2_q, y1_q, x1_q});
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> state_q == ST_CALC)
		else $error("divider finished outside of calc state");

	a_moves_bound: assert property (@(posedge clk) disable iff (!arst_n)
		moves_q <= MOVES_W'(MAX_MOVES))
		else $error("edge move count above limit");

	a_start_nonzero_div: assert property (@(posedge clk) disable iff (!arst_n)
		md_start |-> md != '0)
		else $error("divider started with zero divisor");

	a_apply_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC && md_done |=> state_q == ST_APPLY)
		else $error("quotient not applied after divide");

endmodule

// ===== rtl/csc_outcode.sv =====
// ---------------------------------------------------------------------------
// csc_outcode
// Region code of one point against the clip window.
// ---------------------------------------------------------------------------
module csc_outcode
	import csc_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic signed [COORD_WIDTH-1:0] x,
	input  logic signed [COORD_WIDTH-1:0] y,
	input  logic signed [COORD_WIDTH-1:0] x_min,
	input  logic signed [COORD_WIDTH-1:0] x_max,
	input  logic signed [COORD_WIDTH-1:0] y_min,
	input  logic signed [COORD_WIDTH-1:0] y_max,
	output outcode_t                      code
);

	// points on an edge count as inside
	assign code.left  = (x < x_min);
	assign code.right = (x > x_max);
	assign code.below = (y < y_min);
	assign code.above = (y > y_max);

endmodule

// ===== rtl/csc_muldiv.sv =====
// ---------------------------------------------------------------------------
// csc_muldiv
// Iterative unsigned multiply then divide, (ma * mb) / md, on one shared
// adder: shift-add for the product, restoring steps for the quotient.
// ---------------------------------------------------------------------------
module csc_muldiv
	import csc_pkg::*;
#(
	parameter int DW = COORD_WIDTH_DEF + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] ma,
	input  logic [DW-1:0] mb,
	input  logic [DW-1:0] md,
	output logic [DW-1:0] quot,
	output logic          done
);

	localparam int CNT_W = $clog2(DW);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MUL,
		PH_DIV
	} phase_t;

	phase_t             phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DW-1:0]      hi_q;
	logic [DW-1:0]      lo_q;
	logic [DW-1:0]      ma_q;
	logic [DW-1:0]      md_q;
	logic               done_q;

	logic [DW:0]        op_a;
	logic [DW:0]        op_b;
	logic               cin;
	logic [DW:0]        sum;

	// shared adder
	always_comb begin
		if (phase_q == PH_DIV) begin
			op_a = {hi_q, lo_q[DW-1]};
			op_b = ~{1'b0, md_q};
			cin  = 1'b1;
		end else begin
			op_a = {1'b0, hi_q};
			op_b = lo_q[0] ? {1'b0, ma_q} : '0;
			cin  = 1'b0;
		end
		sum = op_a + op_b + {{DW{1'b0}}, cin};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_MUL;
						cnt_q   <= CNT_W'(DW - 1);
					end
				end
				PH_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						// top half of the product is already below md
						phase_q <= PH_DIV;
						cnt_q   <= CNT_W'(DW - 1);
					end
				end
				PH_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					hi_q <= '0;
					lo_q <= mb;
					ma_q <= ma;
					md_q <= md;
				end
			end
			PH_MUL: begin
				hi_q <= sum[DW:1];
				lo_q <= {sum[0], lo_q[DW-1:1]};
			end
			PH_DIV: begin
				hi_q <= sum[DW] ? op_a[DW-1:0] : sum[DW-1:0];
				lo_q <= {lo_q[DW-2:0], ~sum[DW]};
			end
			default: ;
		endcase
	end

	assign quot = lo_q;
	assign done = done_q;

endmodule

// ===== dv/line_clip_cohen_sutherland_top_tb.sv =====
// ---------------------------------------------------------------------------
// line_clip_cohen_sutherland_top_tb
// Checks the line clipper against a transaction-level predictor. Segments are
// streamed in and each clipped segment is compared field by field, in order.
// The run covers these window settings: the reset window, a typical window,
// inverted windows, degenerate windows, the full coordinate range and random
// windows, one of them small. Both stream sides idle at random, and one long
// output stall backs the block up until it holds off its input.
// ---------------------------------------------------------------------------
module line_clip_cohen_sutherland_top_tb
	import csc_pkg::*;
;

	localparam int     CW             = COORD_WIDTH_DEF;
	localparam int     TDATA_W        = ((4*CW+7)/8)*8;
	localparam int     DRAIN_CYCLES   = 400;
	localparam int     WATCHDOG_LIMIT = 5000;
	localparam int     PHASE_ITEMS    = 255;
	localparam int     PRESSURE_HOLD  = 600;
	localparam longint UNIT           = 64'sd65536;
	localparam longint C_MAX          = 64'sd2147483647;
	localparam longint C_MIN          = -64'sd2147483648;

	// start_x, start_y, end_x, end_y from the lowest bit up
	typedef struct packed {
		logic [CW-1:0] end_y;
		logic [CW-1:0] end_x;
		logic [CW-1:0] start_y;
		logic [CW-1:0] start_x;
	} segment_t;

	// clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y from the lowest bit up
	typedef struct packed {
		logic [CW-1:0] clipped_end_y;
		logic [CW-1:0] clipped_end_x;
		logic [CW-1:0] clipped_start_y;
		logic [CW-1:0] clipped_start_x;
	} clip_t;

	class clip_tracker;
		longint x_min = 0;
		longint x_max = 0;
		longint y_min = 0;
		longint y_max = 0;
		clip_t  pending_clips[$];
		int     mismatches = 0;
		int     clipped_cnt = 0;
		int     dropped_cnt = 0;

		function void set_edge(logic [CFG_INDEX_W-1:0] idx, logic [CW-1:0] v);
			longint val;
			val = longint'(signed'(v));
			case (idx)
				REG_X_MIN: x_min = val;
				REG_X_MAX: x_max = val;
				REG_Y_MIN: y_min = val;
				REG_Y_MAX: y_max = val;
				default: ;
			endcase
		endfunction

		function outcode_t region(longint x, longint y);
			outcode_t c;
			c.left  = x < x_min;
			c.right = x > x_max;
			c.below = y < y_min;
			c.above = y > y_max;
			return c;
		endfunction

		// a1 + trunc((a2 - a1) * (bound - b1) / (b2 - b1)), exact wide product
		function longint edge_cut(longint a1, longint a2, longint b1, longint b2,
				longint bound);
			longint             da, db, dd;
			bit                 neg;
			logic [63:0]        ma, mb, md;
			logic [127:0]       quo;
			da = a2 - a1;
			db = bound - b1;
			dd = b2 - b1;
			if (dd == 0)
				return a1;
			neg = (da < 0) ^ (db < 0) ^ (dd < 0);
			ma  = (da < 0) ? -da : da;
			mb  = (db < 0) ? -db : db;
			md  = (dd < 0) ? -dd : dd;
			quo = ({64'b0, ma} * {64'b0, mb}) / {64'b0, md};
			return neg ? a1 - longint'(quo[63:0]) : a1 + longint'(quo[63:0]);
		endfunction

		function bit clip_segment(segment_t s, output clip_t r);
			longint   x1, y1, x2, y2, nx, ny;
			outcode_t c1, c2, c;
			bit       accepted;
			x1 = longint'(signed'(s.start_x));
			y1 = longint'(signed'(s.start_y));
			x2 = longint'(signed'(s.end_x));
			y2 = longint'(signed'(s.end_y));
			c1 = region(x1, y1);
			c2 = region(x2, y2);
			accepted = 1'b0;
			r = '0;
			for (int m = 0; m <= MAX_MOVES; m++) begin
				if (c1 == '0 && c2 == '0) begin
					accepted = 1'b1;
					break;
				end
				if ((c1 & c2) != '0 || m == MAX_MOVES)
					break;
				c = (c1 != '0) ? c1 : c2;
				if (c.above) begin
					nx = edge_cut(x1, x2, y1, y2, y_max);
					ny = y_max;
				end else if (c.below) begin
					nx = edge_cut(x1, x2, y1, y2, y_min);
					ny = y_min;
				end else if (c.right) begin
					nx = x_max;
					ny = edge_cut(y1, y2, x1, x2, x_max);
				end else begin
					nx = x_min;
					ny = edge_cut(y1, y2, x1, x2, x_min);
				end
				if (c1 != '0) begin
					x1 = nx;
					y1 = ny;
					c1 = region(x1, y1);
				end else begin
					x2 = nx;
					y2 = ny;
					c2 = region(x2, y2);
				end
			end
			if (accepted) begin
				r.clipped_start_x = x1[CW-1:0];
				r.clipped_start_y = y1[CW-1:0];
				r.clipped_end_x   = x2[CW-1:0];
				r.clipped_end_y   = y2[CW-1:0];
			end
			return accepted;
		endfunction

		function void note_segment(segment_t s);
			clip_t r;
			if (clip_segment(s, r)) begin
				pending_clips.insert(pending_clips.size(), r);
				clipped_cnt++;
			end else begin
				dropped_cnt++;
			end
		endfunction

		function void compare_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
				mismatches++;
			end
		endfunction

		function void check_result(clip_t got);
			clip_t want;
			if (pending_clips.size() == 0) begin
				$error("result transaction with no segment pending: %h", got);
				mismatches++;
				return;
			end
			want = pending_clips.pop_front();
			compare_field("clipped_start_x", want.clipped_start_x, got.clipped_start_x);
			compare_field("clipped_start_y", want.clipped_start_y, got.clipped_start_y);
			compare_field("clipped_end_x", want.clipped_end_x, got.clipped_end_x);
			compare_field("clipped_end_y", want.clipped_end_y, got.clipped_end_y);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_X_MIN;
	logic [CW-1:0]          cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_W-1:0]     s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_W-1:0]     m_tdata;

	clip_tracker tracker = new();
	bit          idle_on = 1'b1;
	int          rx_hold = 0;
	int          segments_sent = 0;
	int          windows_loaded = 0;

	line_clip_cohen_sutherland_top #(
		.COORD_WIDTH(CW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// output side: random stall bursts, plus a long hold-off on request
	initial begin : rx_drive
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 4);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			tracker.check_result(m_tdata);
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("line_clip_cohen_sutherland_top test failed");
		$finish;
	end

	function automatic longint rand_between(longint lo, longint hi);
		longint unsigned r;
		r = {$urandom, $urandom};
		return lo + longint'(r % longint'(hi - lo + 1));
	endfunction

	// coordinates clustered around [a, b], with exact edges, full-range and extreme values
	function automatic longint rand_coord(longint a, longint b);
		longint lo, hi, span, v;
		lo   = (a < b) ? a : b;
		hi   = (a < b) ? b : a;
		span = hi - lo;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: v = rand_between(lo - span/2 - 16, hi + span/2 + 16);
			6: v = ($urandom_range(0, 1) ? hi : lo) + longint'($urandom_range(0, 2)) - 1;
			7: v = longint'(signed'($urandom));
			8: v = $urandom_range(0, 1) ? C_MIN : C_MAX;
			default: v = rand_between(lo, hi);
		endcase
		if (v < C_MIN)
			v = C_MIN;
		if (v > C_MAX)
			v = C_MAX;
		return v;
	endfunction

	task automatic send_segment(longint sx, longint sy, longint ex, longint ey);
		segment_t seg;
		seg.start_x = sx[CW-1:0];
		seg.start_y = sy[CW-1:0];
		seg.end_x   = ex[CW-1:0];
		seg.end_y   = ey[CW-1:0];
		if (idle_on && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= seg;
		do @(posedge clk); while (!s_tready);
		tracker.note_segment(seg);
		segments_sent++;
	endtask

	task automatic load_window(longint xlo, longint xhi, longint ylo, longint yhi);
		logic [CFG_INDEX_W-1:0] regs[4];
		longint                 edges[4];
		regs  = '{REG_X_MIN, REG_X_MAX, REG_Y_MIN, REG_Y_MAX};
		edges = '{xlo, xhi, ylo, yhi};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= edges[i][CW-1:0];
			do @(posedge clk); while (!cfg_ready);
			tracker.set_edge(regs[i], edges[i][CW-1:0]);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		windows_loaded++;
	endtask

	// drain: dropped segments leave no trace, so wait out the worst-case latency too
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending_clips.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(longint xlo, longint xhi, longint ylo, longint yhi, int hold);
		settle();
		load_window(xlo, xhi, ylo, yhi);
		rx_hold = hold;
		repeat (PHASE_ITEMS)
			send_segment(rand_coord(xlo, xhi), rand_coord(ylo, yhi),
				rand_coord(xlo, xhi), rand_coord(ylo, yhi));
	endtask

	initial begin : stimulus
		longint wx, wy;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset window is the single point at the origin
		send_segment(0, 0, 0, 0);
		send_segment(-UNIT, -UNIT, UNIT, UNIT);

		settle();
		load_window(-100*UNIT, 100*UNIT, -50*UNIT, 50*UNIT);
		send_segment(-10*UNIT, -10*UNIT, 20*UNIT, 30*UNIT);
		send_segment(-100*UNIT, -50*UNIT, 100*UNIT, 50*UNIT);
		send_segment(-200*UNIT, 0, -150*UNIT, 10*UNIT);
		send_segment(150*UNIT, 0, 300*UNIT, 20*UNIT);
		send_segment(0, -60*UNIT, 10*UNIT, -100*UNIT);
		send_segment(0, 60*UNIT, 5*UNIT, 90*UNIT);
		send_segment(0, 0, 10*UNIT, 100*UNIT);
		send_segment(0, 0, -20*UNIT, -100*UNIT);
		send_segment(0, 0, 200*UNIT, 10*UNIT);
		send_segment(0, 0, -300*UNIT, -20*UNIT);
		send_segment(-200*UNIT, -80*UNIT, 200*UNIT, 80*UNIT);
		send_segment(-150*UNIT, 40*UNIT, -60*UNIT, 90*UNIT);
		send_segment(C_MIN, C_MIN, C_MAX, C_MAX);
		send_segment(C_MAX, C_MIN, C_MIN, C_MAX);
		send_segment(5*UNIT, -200*UNIT, 5*UNIT, 200*UNIT);
		send_segment(-500*UNIT, 7*UNIT, 500*UNIT, 7*UNIT);
		send_segment(3*UNIT, 3*UNIT, 3*UNIT, 3*UNIT);
		send_segment(300*UNIT, 300*UNIT, 300*UNIT, 300*UNIT);
		send_segment(64'h12345, -64'h6789, 200*UNIT + UNIT/2, 70*UNIT + UNIT/4);
		send_segment(-1, -1, 0, 0);

		// inverted x axis: nothing is inside
		settle();
		load_window(UNIT, -UNIT, -UNIT, UNIT);
		send_segment(0, 0, 0, 0);
		send_segment(-2*UNIT, 0, 2*UNIT, 0);

		// x_min equals x_max
		settle();
		load_window(5*UNIT, 5*UNIT, -UNIT, UNIT);
		send_segment(0, 0, 10*UNIT, 0);
		send_segment(5*UNIT, -3*UNIT, 5*UNIT, 3*UNIT);

		random_phase(rand_between(-300*UNIT, 0), rand_between(0, 300*UNIT),
			rand_between(-300*UNIT, 0), rand_between(0, 300*UNIT), PRESSURE_HOLD);
		random_phase(C_MIN, C_MAX, C_MIN, C_MAX, 0);
		wx = rand_between(-50*UNIT, 50*UNIT);
		random_phase(wx, wx, -20*UNIT, 20*UNIT, 0);
		random_phase(-40*UNIT, 40*UNIT, 10*UNIT, -10*UNIT, 0);
		wx = rand_between(-1000, 1000);
		wy = rand_between(-1000, 1000);
		random_phase(wx, wx + $urandom_range(0, 64), wy, wy + $urandom_range(0, 64), 0);

		idle_on = 1'b0;
		random_phase(rand_between(C_MIN, 0), rand_between(0, C_MAX),
			rand_between(-1000*UNIT, 0), rand_between(0, 1000*UNIT), 0);
		settle();

		$display("%0d segments sent over %0d window settings, including inverted,",
			segments_sent, windows_loaded);
		$display("degenerate and full-range windows: %0d clipped and checked, %0d dropped",
			tracker.clipped_cnt, tracker.dropped_cnt);
		if (tracker.mismatches == 0 && tracker.pending_clips.size() == 0)
			$display("line_clip_cohen_sutherland_top test passed");
		else
			$display("line_clip_cohen_sutherland_top test failed");
		$finish;
	end

endmodule
